/* rtl/dspg_pkg.sv */
// Shared constants for the dual stepper pulse generator.
// No dependencies.
`default_nettype none

package dspg_pkg;

	// motor_mode codes
	localparam logic [1:0] MODE_IDLE     = 2'd0;
	localparam logic [1:0] MODE_SPEED    = 2'd1;
	localparam logic [1:0] MODE_POSITION = 2'd2;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MOTOR_MODE  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_PERIOD = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_SPEED = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_SPEED  = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_RIGHT_GOAL  = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEFT_GOAL   = 3'd5;

	localparam int CFG_DATA_BITS  = 32;
	localparam int MODE_BITS      = 2;
	localparam int PERIOD_BITS    = 16;
	localparam int SPEED_BITS     = 13;
	localparam int GOAL_BITS      = 32;
	localparam int OUT_POS_BITS   = 32;
	localparam int COIL_BITS      = 4;
	localparam int ELAPSED_BITS   = 24;

	localparam logic [PERIOD_BITS-1:0] BASE_PERIOD_RESET = 16'd1800;

	// parameter defaults
	localparam int DEF_POSITION_BITS       = 32;
	localparam int DEF_SPEED_FRACTION_BITS = 8;

	// motor slots
	localparam int MOTOR_RIGHT = 0;
	localparam int MOTOR_LEFT  = 1;
	localparam int NUM_MOTORS  = 2;

endpackage

`default_nettype wire

/* rtl/dual_stepper_pulse_generator_top.sv */
// Dual stepper pulse generator: one item per cycle while in_stall is low; the result
// is valid in the cycle after accept. The single state-update path (24x13 multiply
// and compare per motor) sets the clock limit. Depends on dspg_pkg.
// Reset (arst_n low, asynchronous): coils off, positions and timers zero, phases
// zero, base_period 1800, other registers zero, no result pending.
`default_nettype none

module dual_stepper_pulse_generator_top
	import dspg_pkg::*;
#(
	parameter int POSITION_BITS       = DEF_POSITION_BITS,
	parameter int SPEED_FRACTION_BITS = DEF_SPEED_FRACTION_BITS
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write port
	input  wire logic                      cfg_write,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
	// tick channel
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      clear_position,
	// result channel
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [COIL_BITS-1:0]           right_coils,
	output logic [COIL_BITS-1:0]           left_coils,
	output logic signed [OUT_POS_BITS-1:0] right_position,
	output logic signed [OUT_POS_BITS-1:0] left_position,
	output logic                           right_stepped,
	output logic                           left_stepped,
	output logic                           moving
);

	// Compare width for count vs goal: both sign-extended to the wider of the two.
	localparam int CMP_BITS   = (POSITION_BITS > GOAL_BITS) ? POSITION_BITS : GOAL_BITS;
	// Speed product: saturating elapsed times |speed|.
	localparam int PROD_BITS  = ELAPSED_BITS + SPEED_BITS;
	localparam int LIMIT_BITS = PERIOD_BITS + SPEED_FRACTION_BITS;
	localparam int SCMP_BITS  = (PROD_BITS > LIMIT_BITS) ? PROD_BITS : LIMIT_BITS;
	// Slowest speed that still moves: ceil(0.01 in fixed point).
	localparam logic [SPEED_BITS-1:0] MIN_SPEED =
		SPEED_BITS'(((1 << SPEED_FRACTION_BITS) + 99) / 100);
	localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = '1;
	localparam logic [PERIOD_BITS-1:0]  PELAPSED_MAX = '1;

	// ---------------- configuration registers ----------------
	logic [MODE_BITS-1:0]          mode_q;
	logic [PERIOD_BITS-1:0]        base_period_q;
	logic [SPEED_BITS-1:0]         speed_q [NUM_MOTORS];
	logic [GOAL_BITS-1:0]          goal_q  [NUM_MOTORS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_IDLE;
			base_period_q <= BASE_PERIOD_RESET;
			speed_q[MOTOR_RIGHT] <= '0;
			speed_q[MOTOR_LEFT]  <= '0;
			goal_q[MOTOR_RIGHT]  <= '0;
			goal_q[MOTOR_LEFT]   <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MOTOR_MODE:  mode_q        <= cfg_data[MODE_BITS-1:0];
				REG_BASE_PERIOD: base_period_q <= cfg_data[PERIOD_BITS-1:0];
				REG_RIGHT_SPEED: speed_q[MOTOR_RIGHT] <= cfg_data[SPEED_BITS-1:0];
				REG_LEFT_SPEED:  speed_q[MOTOR_LEFT]  <= cfg_data[SPEED_BITS-1:0];
				REG_RIGHT_GOAL:  goal_q[MOTOR_RIGHT]  <= cfg_data[GOAL_BITS-1:0];
				REG_LEFT_GOAL:   goal_q[MOTOR_LEFT]   <= cfg_data[GOAL_BITS-1:0];
				default: ;  // writes past the register list are dropped
			endcase
		end
	end

	// ---------------- motor state ----------------
	logic [1:0]               phase_q   [NUM_MOTORS];
	logic [POSITION_BITS-1:0] count_q   [NUM_MOTORS];
	logic [ELAPSED_BITS-1:0]  elapsed_q [NUM_MOTORS];
	logic [COIL_BITS-1:0]     drive_q   [NUM_MOTORS];
	logic [PERIOD_BITS-1:0]   pos_elapsed_q;

	// ---------------- handshake ----------------
	// The result register holds the stepped flags and a valid bit; the other result
	// fields are the state registers themselves, which only move when a new item
	// loads the result register, so they always match the pending result.
	logic out_valid_q;
	logic step_q [NUM_MOTORS];
	logic accept;

	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;

	// ---------------- next-state logic ----------------
	logic                     pos_fire;
	logic [PERIOD_BITS-1:0]   pos_inc;
	logic [PERIOD_BITS-1:0]   pos_base;
	logic [PERIOD_BITS-1:0]   pos_elapsed_d;

	logic [POSITION_BITS-1:0] cnt_base  [NUM_MOTORS];
	logic [ELAPSED_BITS-1:0]  el_base   [NUM_MOTORS];
	logic [ELAPSED_BITS-1:0]  el_inc    [NUM_MOTORS];
	logic [SPEED_BITS-1:0]    mag       [NUM_MOTORS];
	logic [PROD_BITS-1:0]     prod      [NUM_MOTORS];
	logic signed [CMP_BITS-1:0] cnt_key [NUM_MOTORS];
	logic signed [CMP_BITS-1:0] goal_key[NUM_MOTORS];
	logic                     spd_fire  [NUM_MOTORS];
	logic                     do_step   [NUM_MOTORS];
	logic                     forward   [NUM_MOTORS];
	logic                     phase_up  [NUM_MOTORS];
	logic [1:0]               nxt_phase [NUM_MOTORS];
	logic [1:0]               phase_d   [NUM_MOTORS];
	logic [POSITION_BITS-1:0] count_d   [NUM_MOTORS];
	logic [ELAPSED_BITS-1:0]  elapsed_d [NUM_MOTORS];
	logic [COIL_BITS-1:0]     drive_d   [NUM_MOTORS];
	logic [SCMP_BITS-1:0]     limit;

	assign limit    = SCMP_BITS'(base_period_q) << SPEED_FRACTION_BITS;
	assign pos_base = clear_position ? '0 : pos_elapsed_q;
	assign pos_inc  = (pos_base == PELAPSED_MAX) ? pos_base : pos_base + PERIOD_BITS'(1);
	// a base period of zero fires every tick, same as one
	assign pos_fire = (pos_inc >= base_period_q);

	always_comb begin
		pos_elapsed_d = pos_base;
		if (mode_q == MODE_POSITION) begin
			pos_elapsed_d = pos_fire ? '0 : pos_inc;
		end else if (mode_q != MODE_SPEED) begin
			pos_elapsed_d = '0;
		end

		for (int m = 0; m < NUM_MOTORS; m++) begin
			// clear_position acts before the tick
			cnt_base[m] = clear_position ? '0 : count_q[m];
			el_base[m]  = clear_position ? '0 : elapsed_q[m];
			el_inc[m]   = (el_base[m] == ELAPSED_MAX) ? el_base[m]
			                                          : el_base[m] + ELAPSED_BITS'(1);
			mag[m]      = speed_q[m][SPEED_BITS-1] ? (~speed_q[m] + SPEED_BITS'(1))
			                                       : speed_q[m];
			prod[m]     = PROD_BITS'(el_inc[m]) * PROD_BITS'(mag[m]);
			spd_fire[m] = (mag[m] >= MIN_SPEED) && (SCMP_BITS'(prod[m]) > limit);

			cnt_key[m]  = CMP_BITS'($signed(cnt_base[m]));
			goal_key[m] = CMP_BITS'($signed(goal_q[m]));

			do_step[m] = 1'b0;
			forward[m] = 1'b1;
			if (mode_q == MODE_SPEED) begin
				do_step[m] = spd_fire[m];
				forward[m] = ~speed_q[m][SPEED_BITS-1];
			end else if (mode_q == MODE_POSITION) begin
				do_step[m] = pos_fire && (cnt_key[m] != goal_key[m]);
				forward[m] = (cnt_key[m] < goal_key[m]);
			end

			// left motor is mirrored: phase runs against travel
			phase_up[m]  = forward[m] ^ (m == MOTOR_LEFT);
			nxt_phase[m] = phase_up[m] ? phase_q[m] + 2'd1 : phase_q[m] - 2'd1;

			phase_d[m]   = phase_q[m];
			count_d[m]   = cnt_base[m];
			drive_d[m]   = drive_q[m];
			elapsed_d[m] = el_base[m];

			if (mode_q == MODE_SPEED) begin
				elapsed_d[m] = spd_fire[m] ? '0 : el_inc[m];
			end else if (mode_q != MODE_POSITION) begin
				// idle (and the unused code): release coils, clear counts and timers
				count_d[m]   = '0;
				elapsed_d[m] = '0;
				drive_d[m]   = '0;
			end

			if (do_step[m]) begin
				phase_d[m] = nxt_phase[m];
				drive_d[m] = (COIL_BITS'(1) << phase_q[m]) | (COIL_BITS'(1) << nxt_phase[m]);
				count_d[m] = forward[m] ? cnt_base[m] + POSITION_BITS'(1)
				                        : cnt_base[m] - POSITION_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_elapsed_q <= '0;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				phase_q[m]   <= '0;
				count_q[m]   <= '0;
				elapsed_q[m] <= '0;
				drive_q[m]   <= '0;
				step_q[m]    <= 1'b0;
			end
		end else if (accept) begin
			pos_elapsed_q <= pos_elapsed_d;
			for (int m = 0; m < NUM_MOTORS; m++) begin
				phase_q[m]   <= phase_d[m];
				count_q[m]   <= count_d[m];
				elapsed_q[m] <= elapsed_d[m];
				drive_q[m]   <= drive_d[m];
				step_q[m]    <= do_step[m];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- result fields ----------------
	assign out_valid      = out_valid_q;
	assign right_coils    = drive_q[MOTOR_RIGHT];
	assign left_coils     = drive_q[MOTOR_LEFT];
	// positions leave as the low bits of the count, zero-filled if narrower
	assign right_position = signed'(OUT_POS_BITS'(count_q[MOTOR_RIGHT]));
	assign left_position  = signed'(OUT_POS_BITS'(count_q[MOTOR_LEFT]));
	assign right_stepped  = step_q[MOTOR_RIGHT];
	assign left_stepped   = step_q[MOTOR_LEFT];
	// user must change goals only while no item is in flight (block does not enforce it); live registers are then safe
	assign moving =
		(CMP_BITS'($signed(count_q[MOTOR_RIGHT])) != CMP_BITS'($signed(goal_q[MOTOR_RIGHT])))
		|| (CMP_BITS'($signed(count_q[MOTOR_LEFT])) != CMP_BITS'($signed(goal_q[MOTOR_LEFT])));

	// ---------------- assertions ----------------
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item did not produce a result");

	a_step_two_coils: assert property (@(posedge clk) disable iff (!arst_n)
		step_q[MOTOR_RIGHT] |-> $countones(drive_q[MOTOR_RIGHT]) == 2)
		else $error("right step without a two-coil drive");

	a_left_step_two_coils: assert property (@(posedge clk) disable iff (!arst_n)
		step_q[MOTOR_LEFT] |-> $countones(drive_q[MOTOR_LEFT]) == 2)
		else $error("left step without a two-coil drive");

	a_idle_release: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode_q != MODE_SPEED && mode_q != MODE_POSITION) |=>
		(drive_q[MOTOR_RIGHT] == '0 && drive_q[MOTOR_LEFT] == '0 &&
		 !step_q[MOTOR_RIGHT] && !step_q[MOTOR_LEFT] && count_q[MOTOR_RIGHT] == '0))
		else $error("idle tick left coils driven or a step taken");

endmodule

`default_nettype wire
